>>> rtl/psp_pkg.sv
package psp_pkg;

   localparam int SAMPLE_W     = 32;
   localparam int PEAK_INDEX_W = 10;
   // Magnitude of y3 - y1, its square, and the scaled divisor 8 * |den|.
   localparam int BM_W         = 33;
   localparam int PROD_W       = 2 * BM_W;
   localparam int DEN_W        = 35;
   localparam int DM_W         = 34;
   localparam int D_W          = DM_W + 3;
   localparam int REM_W        = D_W;
   localparam int ALU_W        = 40;
   localparam int STEP_W       = 7;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       is_last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] peak_value;
      logic [PEAK_INDEX_W-1:0]    peak_index;
      logic                       index_valid;
   } rsp_type;

   // Three points around the extreme, captured at the end of a sweep.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] y1;
      logic signed [SAMPLE_W-1:0] y2;
      logic signed [SAMPLE_W-1:0] y3;
      logic [PEAK_INDEX_W-1:0]    index;
      logic                       interior;
   } snap_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SETUP = 6'b000010,
      S_MUL   = 6'b000100,
      S_DIV   = 6'b001000,
      S_ADJ   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

endpackage

>>> rtl/psp_alu.sv
module psp_alu (
   input  logic [psp_pkg::ALU_W-1:0] op_a,
   input  logic [psp_pkg::ALU_W-1:0] op_b,
   input  logic                      sub,
   output logic [psp_pkg::ALU_W:0]   sum
);

   // Carry out of a subtraction is high when op_a >= op_b.
   assign sum = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)}
              + {{psp_pkg::ALU_W{1'b0}}, sub};

endmodule

>>> rtl/psp_track.sv
module psp_track #(
   parameter int MAX_POINTS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  psp_pkg::req_type   req,
   input  logic               find_max,
   output logic               start,
   output psp_pkg::snap_type  snap
);

   localparam int CNT_W = $clog2(MAX_POINTS);

   logic [CNT_W-1:0]  count_ff, count_in, bidx_ff, bidx_in, bidx_n;
   logic signed [31:0] best_ff, best_in, best_n;
   logic signed [31:0] before_ff, before_in, before_n;
   logic signed [31:0] after_ff, after_in, after_n;
   logic signed [31:0] prev_ff, prev_in, prev_n;
   logic              want_ff, want_in, want_n;
   logic              last, better;
   logic [psp_pkg::PEAK_INDEX_W-1:0] bidx_out;

   if (CNT_W >= psp_pkg::PEAK_INDEX_W) begin : g_trunc
      assign bidx_out = bidx_n[psp_pkg::PEAK_INDEX_W-1:0];
   end else begin : g_ext
      assign bidx_out = {{(psp_pkg::PEAK_INDEX_W-CNT_W){1'b0}}, bidx_n};
   end

   always_comb begin
      last   = req.is_last || (count_ff >= CNT_W'(MAX_POINTS - 1));
      better = find_max ? (req.sample > best_ff) : (req.sample < best_ff);

      best_n   = best_ff;
      bidx_n   = bidx_ff;
      before_n = before_ff;
      after_n  = after_ff;
      want_n   = want_ff;
      prev_n   = prev_ff;
      count_in = count_ff;

      if (accept) begin
         if (count_ff == '0) begin
            best_n   = req.sample;
            bidx_n   = '0;
            before_n = '0;
            want_n   = 1'b1;
         end else if (better) begin
            best_n   = req.sample;
            bidx_n   = count_ff;
            before_n = prev_ff;
            want_n   = 1'b1;
         end else if (want_ff) begin
            after_n = req.sample;
            want_n  = 1'b0;
         end
         prev_n   = req.sample;
         count_in = count_ff + CNT_W'(1);
      end

      snap.y1       = before_n;
      snap.y2       = best_n;
      snap.y3       = after_n;
      snap.index    = bidx_out;
      snap.interior = (bidx_n != '0) && (bidx_n < count_ff);
      start         = accept && last;

      best_in   = best_n;
      bidx_in   = bidx_n;
      before_in = before_n;
      after_in  = after_n;
      want_in   = want_n;
      prev_in   = prev_n;

      // The end of a sweep returns all sweep state to zero.
      if (start) begin
         best_in   = '0;
         bidx_in   = '0;
         before_in = '0;
         after_in  = '0;
         want_in   = 1'b0;
         prev_in   = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         bidx_ff   <= '0;
         best_ff   <= '0;
         before_ff <= '0;
         after_ff  <= '0;
         prev_ff   <= '0;
         want_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         bidx_ff   <= bidx_in;
         best_ff   <= best_in;
         before_ff <= before_in;
         after_ff  <= after_in;
         prev_ff   <= prev_in;
         want_ff   <= want_in;
      end
   end

endmodule

>>> rtl/psp_solver.sv
module psp_solver (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  psp_pkg::snap_type snap,
   input  logic              res_ready,
   output logic              idle,
   output logic              res_valid,
   output psp_pkg::rsp_type  res
);

   psp_pkg::state_type state_ff, state_in;

   logic [psp_pkg::STEP_W-1:0]   step_ff, step_in;
   logic signed [31:0]           y1_ff, y2_ff, y3_ff, y1_in, y2_in, y3_in;
   logic [psp_pkg::PEAK_INDEX_W-1:0] index_ff, index_in;
   logic                         interior_ff, interior_in;
   logic [psp_pkg::BM_W-1:0]     bm_ff, bm_in;
   logic [psp_pkg::D_W-1:0]      d_ff, d_in;
   logic                         den_neg_ff, den_neg_in;
   logic [psp_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [psp_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic signed [31:0]           result_ff, result_in;

   logic signed [32:0]                 b_w;
   logic signed [psp_pkg::DEN_W-1:0]   den_w;
   logic [psp_pkg::BM_W-1:0]           bm_w;
   logic [psp_pkg::DM_W-1:0]           dm_w;
   logic [psp_pkg::REM_W:0]            shifted;
   logic [psp_pkg::ALU_W-1:0]          op_a, op_b;
   logic                               sub;
   logic [psp_pkg::ALU_W:0]            alu_sum;
   logic                               q_big;
   logic [psp_pkg::ALU_W-32:0]         top_bits;

   psp_alu u_alu (
      .op_a (op_a),
      .op_b (op_b),
      .sub  (sub),
      .sum  (alu_sum)
   );

   always_comb begin
      b_w   = {y3_ff[31], y3_ff} - {y1_ff[31], y1_ff};
      den_w = psp_pkg::DEN_W'(y1_ff) - (psp_pkg::DEN_W'(y2_ff) <<< 1)
            + psp_pkg::DEN_W'(y3_ff);
      bm_w  = b_w[32] ? psp_pkg::BM_W'(-b_w) : psp_pkg::BM_W'(b_w);
      dm_w  = den_w[psp_pkg::DEN_W-1] ? psp_pkg::DM_W'(-den_w) : psp_pkg::DM_W'(den_w);

      shifted = {rem_ff, prod_ff[psp_pkg::PROD_W-1]};
      q_big   = (prod_ff[psp_pkg::PROD_W-1:35] != '0)
             || (prod_ff[34] && (prod_ff[33:0] != '0));
      top_bits = alu_sum[psp_pkg::ALU_W-1:31];

      op_a = '0;
      op_b = '0;
      sub  = 1'b0;
      case (state_ff)
         psp_pkg::S_MUL: begin
            op_a = psp_pkg::ALU_W'(prod_ff[psp_pkg::PROD_W-1:psp_pkg::BM_W]);
            op_b = prod_ff[0] ? psp_pkg::ALU_W'(bm_ff) : '0;
         end
         psp_pkg::S_DIV: begin
            op_a = psp_pkg::ALU_W'(shifted);
            op_b = psp_pkg::ALU_W'(d_ff);
            sub  = 1'b1;
         end
         psp_pkg::S_ADJ: begin
            op_a = psp_pkg::ALU_W'(y2_ff);
            op_b = psp_pkg::ALU_W'(prod_ff[34:0]);
            sub  = !den_neg_ff;
         end
         default: begin
         end
      endcase

      state_in    = state_ff;
      step_in     = step_ff;
      y1_in       = y1_ff;
      y2_in       = y2_ff;
      y3_in       = y3_ff;
      index_in    = index_ff;
      interior_in = interior_ff;
      bm_in       = bm_ff;
      d_in        = d_ff;
      den_neg_in  = den_neg_ff;
      prod_in     = prod_ff;
      rem_in      = rem_ff;
      result_in   = result_ff;

      case (state_ff)
         psp_pkg::S_IDLE: begin
            if (start) begin
               y1_in       = snap.y1;
               y2_in       = snap.y2;
               y3_in       = snap.y3;
               index_in    = snap.index;
               interior_in = snap.interior;
               state_in    = psp_pkg::S_SETUP;
            end
         end
         psp_pkg::S_SETUP: begin
            bm_in      = bm_w;
            d_in       = {dm_w, 3'b000};
            den_neg_in = den_w[psp_pkg::DEN_W-1];
            prod_in    = {{(psp_pkg::PROD_W-psp_pkg::BM_W){1'b0}}, bm_w};
            rem_in     = '0;
            step_in    = '0;
            result_in  = y2_ff;
            // Extreme at an end, equal neighbors or a flat curve give the plain extreme.
            if (!interior_ff || (y1_ff == y3_ff) || (den_w == '0)) begin
               state_in = psp_pkg::S_DONE;
            end else begin
               state_in = psp_pkg::S_MUL;
            end
         end
         psp_pkg::S_MUL: begin
            prod_in = {alu_sum[psp_pkg::BM_W:0], prod_ff[psp_pkg::BM_W-1:1]};
            step_in = step_ff + psp_pkg::STEP_W'(1);
            if (step_ff == psp_pkg::STEP_W'(psp_pkg::BM_W - 1)) begin
               step_in  = '0;
               state_in = psp_pkg::S_DIV;
            end
         end
         psp_pkg::S_DIV: begin
            rem_in  = alu_sum[psp_pkg::ALU_W] ? alu_sum[psp_pkg::REM_W-1:0]
                                              : shifted[psp_pkg::REM_W-1:0];
            prod_in = {prod_ff[psp_pkg::PROD_W-2:0], alu_sum[psp_pkg::ALU_W]};
            step_in = step_ff + psp_pkg::STEP_W'(1);
            if (step_ff == psp_pkg::STEP_W'(psp_pkg::PROD_W - 1)) begin
               step_in  = '0;
               state_in = psp_pkg::S_ADJ;
            end
         end
         psp_pkg::S_ADJ: begin
            if (q_big) begin
               result_in = den_neg_ff ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            end else if ((top_bits != '0) && (top_bits != '1)) begin
               result_in = top_bits[psp_pkg::ALU_W-32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
               result_in = alu_sum[31:0];
            end
            state_in = psp_pkg::S_DONE;
         end
         psp_pkg::S_DONE: begin
            if (res_ready) begin
               state_in = psp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = psp_pkg::S_IDLE;
         end
      endcase
   end

   assign idle            = (state_ff == psp_pkg::S_IDLE);
   assign res_valid       = (state_ff == psp_pkg::S_DONE);
   assign res.peak_value  = result_ff;
   assign res.peak_index  = index_ff;
   assign res.index_valid = interior_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psp_pkg::S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      y1_ff       <= y1_in;
      y2_ff       <= y2_in;
      y3_ff       <= y3_in;
      index_ff    <= index_in;
      interior_ff <= interior_in;
      bm_ff       <= bm_in;
      d_ff        <= d_in;
      den_neg_ff  <= den_neg_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      result_ff   <= result_in;
   end

endmodule

>>> rtl/peak_search_parabolic.sv
// Parabolic peak search over one sweep. Each word on the request channel carries one
// signed Q16.16 sample; the block keeps the running maximum (csr_wr_data = 1, the reset
// value) or minimum, first occurrence winning on ties, together with its two neighbors.
// Samples are taken one per cycle while req_stall is low. The last sample of a sweep
// (is_last, or the sample at index MAX_POINTS-1) produces one response word: the
// parabola vertex y2 - (y3-y1)^2 / (8*(y1-2*y2+y3)), correction truncated toward
// zero and the sum saturated to 32 bits. When the extreme sits at either end of the
// sweep the plain extreme is returned with index_valid low; equal neighbors or a zero
// denominator also return the plain extreme, with index_valid high. After the last
// sample the request channel stalls while a single shared adder works the result:
// setup, 33 shift-add squaring steps, 66 restoring division steps, the final add and
// the hand-off to the output register, or setup and the hand-off alone when no
// interpolation is needed. The hand-off waits while the output register still holds
// a word that has not been taken, which lengthens the stall by that wait.
// The response sits in an output register, so a new sweep can stream in while it waits
// to be taken. Configuration writes belong between sweeps.
module peak_search_parabolic #(
   parameter int MAX_POINTS = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  psp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output psp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   logic              find_max_ff, find_max_in;
   logic              rsp_valid_ff, rsp_valid_in;
   psp_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic              accept, start, solver_idle, res_valid, res_ready;
   psp_pkg::snap_type snap;
   psp_pkg::rsp_type  res;

   // Samples are refused only while the solver is busy with a finished sweep.
   assign req_stall = !solver_idle;
   assign accept    = req_valid && !req_stall;

   psp_track #(
      .MAX_POINTS (MAX_POINTS)
   ) u_track (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .find_max (find_max_ff),
      .start    (start),
      .snap     (snap)
   );

   psp_solver u_solver (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .snap      (snap),
      .res_ready (res_ready),
      .idle      (solver_idle),
      .res_valid (res_valid),
      .res       (res)
   );

   // The output register takes a new word when it is empty or being emptied.
   assign res_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      find_max_in  = csr_wr_en ? csr_wr_data : find_max_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         find_max_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         find_max_ff  <= find_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
